FILE: rtl/csue_pkg.sv
package csue_pkg;

    // Sketch geometry
    localparam int ROWS         = 5;
    localparam int BUCKET_BITS  = 10;
    localparam int COUNTER_BITS = 32;

    localparam int NBUCKETS  = 1 << BUCKET_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_DEPTH = ROWS * NBUCKETS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int RANK_W    = $clog2(ROWS + 1);
    localparam int VAL_W     = COUNTER_BITS + 1;

    // Hash fold: (u >> 89) + (u mod 2^89), only the low bits are needed
    localparam int KEY_W      = 64;
    localparam int HALF_W     = 32;
    localparam int FOLD_SHIFT = 89;
    localparam int FOLD_W     = BUCKET_BITS;
    localparam int U_W        = FOLD_SHIFT + FOLD_W;
    localparam int WIDE_W     = 2 * KEY_W;

    // Coefficient slots of one row
    localparam int NSLOTS          = 4;
    localparam int SLOT_BUCKET_MUL = 0;
    localparam int SLOT_BUCKET_OFS = 1;
    localparam int SLOT_SIGN_MUL   = 2;
    localparam int SLOT_SIGN_OFS   = 3;

    // Result fields
    localparam int EST_W  = 31;
    localparam int ITEM_W = 48;
    localparam int FRAC_W = 16;
    localparam int PROD_W = ITEM_W + FRAC_W;
    localparam int CLAMP_W = (VAL_W > EST_W + 2) ? VAL_W + 1 : EST_W + 2;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd655;
    localparam logic [ITEM_W-1:0] ITEM_MAX   = {ITEM_W{1'b1}};

    localparam logic signed [COUNTER_BITS-1:0] CNT_MAX =
        {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic signed [COUNTER_BITS-1:0] CNT_MIN =
        {1'b1, {(COUNTER_BITS-1){1'b0}}};

    // Operation codes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_ESTIMATE = 2'd1;
    localparam logic [1:0] OP_COEFF    = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [3:0]       coeff_row;
        logic [1:0]       coeff_slot;
        logic [KEY_W-1:0] coeff_value;
    } req_beat_t;

    typedef struct packed {
        logic [EST_W-1:0]  estimate;
        logic              candidate;
        logic [ITEM_W-1:0] items_added;
    } rsp_beat_t;

endpackage

FILE: rtl/csue_ram.sv
module csue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/csue_hash.sv
module csue_hash (
    input  logic                          clk,
    input  logic [csue_pkg::KEY_W-1:0]    coef_a,
    input  logic [csue_pkg::KEY_W-1:0]    coef_b,
    input  logic [csue_pkg::KEY_W-1:0]    key,
    output logic [csue_pkg::FOLD_W-1:0]   fold
);

    import csue_pkg::*;

    logic [KEY_W-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [KEY_W-1:0]  b_reg;
    logic [U_W-1:0]    u_reg;
    logic [FOLD_W-1:0] fold_reg;
    logic [WIDE_W-1:0] u_wide;

    // Sum the partial products and the offset into a*key + b
    assign u_wide = WIDE_W'(p00_reg)
                  + (WIDE_W'(p01_reg) << HALF_W)
                  + (WIDE_W'(p10_reg) << HALF_W)
                  + (WIDE_W'(p11_reg) << KEY_W)
                  + WIDE_W'(b_reg);

    // Three stages: 32x32 products, full sum, fold of the low bits
    always_ff @(posedge clk)
    begin
        p00_reg  <= KEY_W'(coef_a[HALF_W-1:0]) * KEY_W'(key[HALF_W-1:0]);
        p01_reg  <= KEY_W'(coef_a[HALF_W-1:0]) * KEY_W'(key[KEY_W-1:HALF_W]);
        p10_reg  <= KEY_W'(coef_a[KEY_W-1:HALF_W]) * KEY_W'(key[HALF_W-1:0]);
        p11_reg  <= KEY_W'(coef_a[KEY_W-1:HALF_W]) * KEY_W'(key[KEY_W-1:HALF_W]);
        b_reg    <= coef_b;
        u_reg    <= u_wide[U_W-1:0];
        fold_reg <= u_reg[FOLD_W-1:0] + u_reg[FOLD_SHIFT +: FOLD_W];
    end

    assign fold = fold_reg;

endmodule

FILE: rtl/count_sketch_update_estimate_unit.sv
// Channel  Direction  Beat type    Handshake
// req      in         req_beat_t   req_valid / req_ready
// rsp      out        rsp_beat_t   rsp_valid / rsp_ready
// cfg      in         16 bits      cfg_we, no wait
//
// Add and estimate stream one row a cycle through the coefficient memory,
// the hash pipeline and the counter memory, then the median scans the rows
// one candidate a cycle. Coefficient writes and unused codes go from idle
// straight to the done state. After reset all ROWS*2^BUCKET_BITS entries
// (5120) of the counter memory are cleared, one entry a cycle, before
// req_ready rises.
// One item is in work at a time; a finished beat waits in the output
// register while the next item is accepted.
module count_sketch_update_estimate_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  csue_pkg::req_beat_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output csue_pkg::rsp_beat_t           rsp,
    input  logic                          cfg_we,
    input  logic [csue_pkg::FRAC_W-1:0]   cfg_data
);

    import csue_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_MED,
        S_CLAMP,
        S_DONE
    } state_t;

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [CNT_AW-1:0] CLR_LAST  = CNT_AW'(CNT_DEPTH - 1);
    localparam logic [RANK_W-1:0] RANK_MED  = RANK_W'(ROWS / 2);
    localparam int                NSTAGES   = 5;

    state_t               state_reg;
    logic [CNT_AW-1:0]    clr_addr_reg;
    logic                 iss_on_reg;
    logic [ROW_W-1:0]     iss_row_reg;
    logic [NSTAGES-1:0]   v_reg;
    logic [ROW_W-1:0]     row_reg [NSTAGES];
    logic [ROW_W-1:0]     med_i_reg;
    logic [ITEM_W-1:0]    item_count_reg;
    logic [FRAC_W-1:0]    min_frac_reg;
    logic                 rsp_valid_reg;
    rsp_beat_t            rsp_reg;

    logic [1:0]           op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 sign_reg;
    logic [CNT_AW-1:0]    addr_s4_reg;
    logic signed [VAL_W-1:0] vals_reg [ROWS];
    logic signed [VAL_W-1:0] med_reg;
    logic [EST_W-1:0]     est_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 req_fire;
    logic                 coeff_hit;
    logic [KEY_W-1:0]     coef_rd [NSLOTS];
    logic [FOLD_W-1:0]    bfold, sfold;
    logic [ROW_W+BUCKET_BITS-1:0] addr_wide;
    logic [CNT_AW-1:0]    cnt_raddr;
    logic [CNT_AW-1:0]    cnt_waddr;
    logic [COUNTER_BITS-1:0] cnt_rdata;
    logic [COUNTER_BITS-1:0] cnt_wdata;
    logic                 cnt_we;
    logic signed [COUNTER_BITS-1:0] cnt_old, cnt_new;
    logic signed [VAL_W-1:0] val_s4;
    logic signed [VAL_W-1:0] med_pick;
    logic [RANK_W-1:0]    rank;
    logic signed [CLAMP_W-1:0] med_ext;
    logic [EST_W-1:0]     est_clamp;
    logic                 cand;
    logic                 rsp_load;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign coeff_hit = req_fire && (req.operation == OP_COEFF)
                     && (5'(req.coeff_row) < 5'(ROWS));

    // Coefficient memories, one per slot, addressed by row
    for (genvar s = 0; s < NSLOTS; s++)
    begin : g_coef
        csue_ram #(
            .WIDTH (KEY_W),
            .DEPTH (ROWS)
        ) u_coef_ram (
            .clk   (clk),
            .we    (coeff_hit && (req.coeff_slot == 2'(s))),
            .waddr (req.coeff_row[ROW_W-1:0]),
            .wdata (req.coeff_value),
            .raddr (iss_row_reg),
            .rdata (coef_rd[s])
        );
    end

    csue_hash u_bucket_hash (
        .clk    (clk),
        .coef_a (coef_rd[SLOT_BUCKET_MUL]),
        .coef_b (coef_rd[SLOT_BUCKET_OFS]),
        .key    (key_reg),
        .fold   (bfold)
    );

    csue_hash u_sign_hash (
        .clk    (clk),
        .coef_a (coef_rd[SLOT_SIGN_MUL]),
        .coef_b (coef_rd[SLOT_SIGN_OFS]),
        .key    (key_reg),
        .fold   (sfold)
    );

    // Counter address from row tag and bucket
    assign addr_wide = {row_reg[3], bfold};
    assign cnt_raddr = addr_wide[CNT_AW-1:0];

    // Saturating counter step and sign correction
    assign cnt_old = signed'(cnt_rdata);
    always_comb
    begin
        cnt_new = cnt_old;
        if (op_reg == OP_ADD)
        begin
            if (sign_reg)
            begin
                if (cnt_old < CNT_MAX)
                begin
                    cnt_new = cnt_old + COUNTER_BITS'(1);
                end
            end
            else
            begin
                if (cnt_old > CNT_MIN)
                begin
                    cnt_new = cnt_old - COUNTER_BITS'(1);
                end
            end
        end
    end
    assign val_s4 = sign_reg ? VAL_W'(cnt_new) : -VAL_W'(cnt_new);

    // Clear sweep or write back
    assign cnt_we    = (state_reg == S_CLEAR) || (v_reg[4] && (op_reg == OP_ADD));
    assign cnt_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : addr_s4_reg;
    assign cnt_wdata = (state_reg == S_CLEAR) ? '0 : cnt_new;

    csue_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Rank of one candidate against all rows; ties broken by row order
    assign med_pick = vals_reg[med_i_reg];
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < ROWS; j++)
        begin
            if ((vals_reg[j] < med_pick)
                || ((vals_reg[j] == med_pick) && (ROW_W'(j) < med_i_reg)))
            begin
                rank = rank + RANK_W'(1);
            end
        end
    end

    // Clamp the median to the estimate range
    assign med_ext = CLAMP_W'(med_reg);
    always_comb
    begin
        if (med_ext < 0)
        begin
            est_clamp = '0;
        end
        else if (med_ext > CLAMP_W'({EST_W{1'b1}}))
        begin
            est_clamp = {EST_W{1'b1}};
        end
        else
        begin
            est_clamp = med_ext[EST_W-1:0];
        end
    end

    assign cand     = (op_reg == OP_ADD)
                   && (PROD_W'({est_reg, 16'b0}) >= prod_reg);
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            iss_on_reg     <= 1'b0;
            iss_row_reg    <= '0;
            v_reg          <= '0;
            med_i_reg      <= '0;
            item_count_reg <= '0;
            min_frac_reg   <= FRAC_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_frac_reg <= cfg_data;
            end

            v_reg <= {v_reg[NSTAGES-2:0], iss_on_reg};

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + CNT_AW'(1);
                    if (clr_addr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if ((req.operation == OP_ADD) || (req.operation == OP_ESTIMATE))
                        begin
                            iss_on_reg  <= 1'b1;
                            iss_row_reg <= '0;
                            state_reg   <= S_RUN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                        if ((req.operation == OP_ADD) && (item_count_reg != ITEM_MAX))
                        begin
                            item_count_reg <= item_count_reg + ITEM_W'(1);
                        end
                    end
                end
                S_RUN:
                begin
                    if (iss_on_reg)
                    begin
                        if (iss_row_reg == ROW_LAST)
                        begin
                            iss_on_reg <= 1'b0;
                        end
                        else
                        begin
                            iss_row_reg <= iss_row_reg + ROW_W'(1);
                        end
                    end
                    if (v_reg[4] && (row_reg[4] == ROW_LAST))
                    begin
                        med_i_reg <= '0;
                        state_reg <= S_MED;
                    end
                end
                S_MED:
                begin
                    if (med_i_reg == ROW_LAST)
                    begin
                        state_reg <= S_CLAMP;
                    end
                    else
                    begin
                        med_i_reg <= med_i_reg + ROW_W'(1);
                    end
                end
                S_CLAMP:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        row_reg[0] <= iss_row_reg;
        for (int k = 1; k < NSTAGES; k++)
        begin
            row_reg[k] <= row_reg[k-1];
        end
        sign_reg    <= sfold[0];
        addr_s4_reg <= cnt_raddr;

        if (req_fire)
        begin
            op_reg  <= req.operation;
            key_reg <= req.key;
            est_reg <= '0;
        end

        if (v_reg[4])
        begin
            vals_reg[row_reg[4]] <= val_s4;
        end

        if ((state_reg == S_MED) && (rank == RANK_MED))
        begin
            med_reg <= med_pick;
        end

        if (state_reg == S_CLAMP)
        begin
            est_reg  <= est_clamp;
            prod_reg <= PROD_W'(item_count_reg) * PROD_W'(min_frac_reg);
        end

        if (rsp_load)
        begin
            rsp_reg.estimate    <= est_reg;
            rsp_reg.candidate   <= cand;
            rsp_reg.items_added <= item_count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
